[sv/bei_pkg.sv]
`default_nettype none

package bei_pkg;

  localparam int BUF_BYTES = 256;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic        op;
    logic        is_signed;
    logic [10:0] bit_offset;
    logic [6:0]  bit_count;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        error;
  } rsp_t;

  // Decoded request held while the two buffer words are read back.
  typedef struct packed {
    logic         op;
    logic         err;
    logic         wodd;      // first word of the window sits in the odd bank
    logic [4:0]   word;      // 64-bit word holding the field's first bit
    logic [7:0]   sh;        // right shift that aligns a get field to bit 0
    logic [6:0]   sidx;      // window index of the field's first bit
    logic         sext;
    logic [63:0]  fmask;
    logic [63:0]  smask;
    logic [127:0] wmask;
    logic [127:0] wdata;
  } s1_t;

  typedef struct packed {
    logic        we_even;
    logic        we_odd;
    logic [63:0] even_data;
    logic [63:0] odd_data;
  } wb_t;

  // Row of each bank that covers word w and word w+1.
  function automatic logic [31:0] row_even(input logic [4:0] w);
    logic [5:0] wp1;
    wp1 = {1'b0, w} + 6'd1;
    return 32'(wp1 >> 1);
  endfunction

  function automatic logic [31:0] row_odd(input logic [4:0] w);
    return 32'(w >> 1);
  endfunction

endpackage

`default_nettype wire

[sv/bitfield_extract_insert.sv]
// An accepted request is registered in s1_q while both banks read its rows; the
//   merged result is then registered in rsp_q, later only while rsp_stall_i holds it.
// A new request is taken only once the last has done its read and write-back of
//   the two 64-bit RAM banks (one read and one write port each) that hold the buffer.
// Reset: async, active low; afterwards a clearing pass zeroes the buffer, one row
//   of each bank per cycle over all ceil(BufBytes/16) rows, with req_stall_o high.
`default_nettype none

module bitfield_extract_insert #(
  parameter int BufBytes = bei_pkg::BUF_BYTES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire bei_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output bei_pkg::rsp_t      rsp_o
);
  import bei_pkg::*;

  localparam int Words = (BufBytes + 7) / 8;
  localparam int Rows  = (Words + 1) / 2;
  localparam int Aw    = (Rows > 1) ? $clog2(Rows) : 1;

  logic          clr_q, clr_d;
  logic [Aw-1:0] clr_cnt_q, clr_cnt_d;
  logic          s1_valid_q, s1_valid_d;
  s1_t           s1_q, s1_d;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          accept;
  logic          fin;
  rsp_t          mrg_rsp;
  wb_t           wb;
  logic [31:0]   rd_even_row, rd_odd_row, wr_even_row, wr_odd_row;
  logic [63:0]   even_rd, odd_rd;
  logic          we_even, we_odd;
  logic [Aw-1:0] wa_even, wa_odd;
  logic [63:0]   wd_even, wd_odd;

  bei_prep #(.BufBytes(BufBytes)) u_prep (
    .req_i (req_i),
    .s1_o  (s1_d)
  );

  bei_merge u_merge (
    .s1_i      (s1_q),
    .even_rd_i (even_rd),
    .odd_rd_i  (odd_rd),
    .rsp_o     (mrg_rsp),
    .wb_o      (wb)
  );

  assign req_stall_o = clr_q | s1_valid_q;
  assign accept      = req_valid_i & ~req_stall_o;
  // writes land only when the response register can take the result
  assign fin         = s1_valid_q & (~rsp_valid_q | ~rsp_stall_i);

  always_comb begin
    rd_even_row = row_even(req_i.bit_offset[10:6]);
    rd_odd_row  = row_odd(req_i.bit_offset[10:6]);
    wr_even_row = row_even(s1_q.word);
    wr_odd_row  = row_odd(s1_q.word);
    if (clr_q) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      wa_even = clr_cnt_q;
      wa_odd  = clr_cnt_q;
      wd_even = 64'd0;
      wd_odd  = 64'd0;
    end else begin
      we_even = fin & wb.we_even;
      we_odd  = fin & wb.we_odd;
      wa_even = wr_even_row[Aw-1:0];
      wa_odd  = wr_odd_row[Aw-1:0];
      wd_even = wb.even_data;
      wd_odd  = wb.odd_data;
    end
  end

  bei_ram #(.Width(64), .Depth(Rows), .Aw(Aw)) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (wa_even),
    .wdata_i (wd_even),
    .re_i    (accept),
    .raddr_i (rd_even_row[Aw-1:0]),
    .rdata_o (even_rd)
  );

  bei_ram #(.Width(64), .Depth(Rows), .Aw(Aw)) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (wa_odd),
    .wdata_i (wd_odd),
    .re_i    (accept),
    .raddr_i (rd_odd_row[Aw-1:0]),
    .rdata_o (odd_rd)
  );

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + Aw'(1);
      if (clr_cnt_q == Aw'(Rows - 1)) begin
        clr_d = 1'b0;
      end
    end

    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fin) begin
      s1_valid_d = 1'b0;
    end

    rsp_valid_d = rsp_valid_q & rsp_stall_i;
    rsp_d       = rsp_q;
    if (fin) begin
      rsp_valid_d = 1'b1;
      rsp_d       = mrg_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

[sv/bei_ram.sv]
`default_nettype none

module bei_ram #(
  parameter int Width = 64,
  parameter int Depth = 16,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/bei_prep.sv]
`default_nettype none

module bei_prep #(
  parameter int BufBytes = bei_pkg::BUF_BYTES
) (
  input  wire bei_pkg::req_t req_i,
  output bei_pkg::s1_t       s1_o
);
  import bei_pkg::*;

  localparam int TotalBits = BufBytes * 8;

  logic [11:0]  end_bit;
  logic         range_err;
  logic         width_err;
  logic [5:0]   b;
  logic [6:0]   cnt;
  logic [5:0]   cm1;
  logic [31:0]  lowm;
  logic [31:0]  field;
  logic         narrow_sgn;
  logic [6:0]   sh_l;
  logic [127:0] ins;
  logic [127:0] msk;

  always_comb begin
    cnt       = req_i.bit_count;
    b         = req_i.bit_offset[5:0];
    end_bit   = {1'b0, req_i.bit_offset} + {5'd0, cnt};
    range_err = 32'(end_bit) > 32'(TotalBits);
    width_err = (req_i.op == OP_SET) ? (cnt > 7'd32) : (cnt > 7'd64);

    // set: signed narrow fields keep the sign bit on top
    cm1        = cnt[5:0] - 6'd1;
    lowm       = 32'((33'd1 << cm1[4:0]) - 33'd1);
    narrow_sgn = req_i.is_signed && (cnt != 7'd0) && (cnt < 7'd32);
    field      = narrow_sgn ? ((req_i.write_value & lowm) |
                               ({31'd0, req_i.write_value[31]} << cm1[4:0]))
                            : req_i.write_value;
    sh_l = 7'd32 - cnt;
    ins  = ({field, 96'd0} << sh_l) >> b;
    msk  = ({32'hFFFF_FFFF, 96'd0} << sh_l) >> b;

    s1_o.op    = req_i.op;
    s1_o.err   = range_err | width_err;
    s1_o.word  = req_i.bit_offset[10:6];
    s1_o.wodd  = req_i.bit_offset[6];
    s1_o.sh    = 8'd128 - {2'd0, b} - {1'b0, cnt};
    s1_o.sidx  = 7'd127 - {1'b0, b};
    s1_o.sext  = req_i.is_signed && (cnt != 7'd0) && (cnt < 7'd64);
    s1_o.fmask = (cnt == 7'd0) ? 64'd0 : (~64'd0 >> (7'd64 - cnt));
    s1_o.smask = ~64'd0 << cnt;
    s1_o.wmask = msk;
    s1_o.wdata = ins & msk;
  end

endmodule

`default_nettype wire

[sv/bei_merge.sv]
`default_nettype none

module bei_merge (
  input  wire bei_pkg::s1_t  s1_i,
  input  wire logic [63:0]   even_rd_i,
  input  wire logic [63:0]   odd_rd_i,
  output bei_pkg::rsp_t      rsp_o,
  output bei_pkg::wb_t       wb_o
);
  import bei_pkg::*;

  logic [127:0] win;
  logic [63:0]  ext;
  logic [63:0]  rv;
  logic [63:0]  hi_new;
  logic [63:0]  lo_new;
  logic         wr_ok;
  logic         we_hi;
  logic         we_lo;

  always_comb begin
    win = s1_i.wodd ? {odd_rd_i, even_rd_i} : {even_rd_i, odd_rd_i};

    ext = 64'(win >> s1_i.sh) & s1_i.fmask;
    rv  = ext | ((s1_i.sext && win[s1_i.sidx]) ? s1_i.smask : 64'd0);

    rsp_o.read_value = ((s1_i.op == OP_GET) && !s1_i.err) ? rv : 64'd0;
    rsp_o.error      = s1_i.err;

    hi_new = (win[127:64] & ~s1_i.wmask[127:64]) | s1_i.wdata[127:64];
    lo_new = (win[63:0] & ~s1_i.wmask[63:0]) | s1_i.wdata[63:0];
    wr_ok  = (s1_i.op == OP_SET) && !s1_i.err;
    we_hi  = wr_ok && (|s1_i.wmask[127:64]);
    we_lo  = wr_ok && (|s1_i.wmask[63:0]);

    wb_o.we_even   = s1_i.wodd ? we_lo : we_hi;
    wb_o.we_odd    = s1_i.wodd ? we_hi : we_lo;
    wb_o.even_data = s1_i.wodd ? lo_new : hi_new;
    wb_o.odd_data  = s1_i.wodd ? hi_new : lo_new;
  end

endmodule

`default_nettype wire

[sv/bei_checker.sv]
`default_nettype none

module bei_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_stall_o,
  input wire bei_pkg::req_t req_i,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_stall_i,
  input wire bei_pkg::rsp_t rsp_o
);

  // held response stays put
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("request accepted back to back");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.error |-> rsp_o.read_value == 64'd0)
    else $error("refused access returned data");

  // registers may still be unknown at the first reset edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> req_stall_o && !rsp_valid_o)
    else $error("ports active during reset");

endmodule

bind bitfield_extract_insert bei_checker u_bei_checker (.*);

`default_nettype wire
